// ===== sv/cc20_pkg.sv =====
// Shared types, constants and round functions for the ChaCha20 stream cipher.
package cc20_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Configuration register indexes (byte address / 8).
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;

    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    typedef logic [15:0][31:0] t_block;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_lo;
        logic [31:0]      nonce_hi;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [5:0]  pos;
        logic [31:0] ctr;
    } t_item;

    function automatic t_block build_init(t_cfg cfg, logic [31:0] ctr);
        t_block s;
        s[0]  = SIGMA[0];
        s[1]  = SIGMA[1];
        s[2]  = SIGMA[2];
        s[3]  = SIGMA[3];
        for (int n = 0; n < 4; n++) begin
            s[4 + 2 * n] = cfg.key[n][31:0];
            s[5 + 2 * n] = cfg.key[n][63:32];
        end
        s[12] = ctr;
        s[13] = cfg.nonce_lo[31:0];
        s[14] = cfg.nonce_lo[63:32];
        s[15] = cfg.nonce_hi;
        return s;
    endfunction

    // Rotate left by 16, 12, 8, 7 for the four lines of a quarter round.
    function automatic logic [31:0] rotl_step(logic [31:0] v, logic [1:0] step);
        logic [31:0] r;
        case (step)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            default: r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

    // One line of the quarter round, applied to all four quarters at once.
    function automatic t_block qr_step(t_block w, logic diag, logic [1:0] step);
        t_block      r;
        logic [3:0]  a, b, c, d, x, y, z;
        logic [31:0] s;
        r = w;
        for (int q = 0; q < 4; q++) begin
            a = 4'(q);
            b = diag ? 4'(4 + ((q + 1) & 3)) : 4'(4 + q);
            c = diag ? 4'(8 + ((q + 2) & 3)) : 4'(8 + q);
            d = diag ? 4'(12 + ((q + 3) & 3)) : 4'(12 + q);
            x = step[0] ? c : a;
            y = step[0] ? d : b;
            z = step[0] ? b : d;
            s = r[x] + r[y];
            r[x] = s;
            r[z] = rotl_step(r[z] ^ s, step);
        end
        return r;
    endfunction

endpackage

// ===== sv/cc20_if.sv =====
// Byte stream channel interfaces for the ChaCha20 stream cipher.
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_message;
    modport source (output valid, data_byte, last_in_message, input ready);
    modport sink (input valid, data_byte, last_in_message, output ready);
endinterface

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    modport source (output valid, out_byte, out_last, input ready);
    modport sink (input valid, out_byte, out_last, output ready);
endinterface

// ===== sv/cc20_fifo.sv =====
// Short queue of classified bytes between the front and back ends.
module cc20_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cc20_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output cc20_pkg::t_item o_head
);

    cc20_pkg::t_item r_mem [cc20_pkg::QDEPTH];
    logic [cc20_pkg::QAW-1:0] r_wp, r_rp;
    logic [cc20_pkg::QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (cc20_pkg::QAW+1)'(cc20_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/cc20_front.sv =====
// Front end: accepts bytes and tags each with its block position and counter.
module cc20_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cc20_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output cc20_pkg::t_item o_item
);

    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_ctr, n_ctr;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.data = i_in.data_byte;
        o_item.last = i_in.last_in_message;
        o_item.pos  = r_pos;
        o_item.ctr  = r_ctr;
        n_pos = r_pos + 1'b1;
        n_ctr = (r_pos == '0) ? r_ctr + 1'b1 : r_ctr;
        // end of message: restart position and counter
        if (i_in.last_in_message) begin
            n_pos = '0;
            n_ctr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ctr <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
            r_ctr <= n_ctr;
        end
    end

endmodule

// ===== sv/cc20_back.sv =====
// Back end: block generator, keystream store and output register.
module cc20_back #(
    parameter int ROUND_COUNT = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cc20_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    input  cc20_pkg::t_item i_head,
    output logic            o_pop,
    cc20_out_if.source      o_out
);

    localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       r_step;
    logic [RW-1:0]    r_rnd;
    logic             r_have;
    cc20_pkg::t_block r_w;
    cc20_pkg::t_block init_w;
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_ol;
    logic             can_out;
    logic             start;
    logic [31:0]      ks_word;
    logic [7:0]       ks_byte;

    assign init_w  = cc20_pkg::build_init(i_cfg, i_head.ctr);
    assign can_out = !r_ov || o_out.ready;
    assign start   = (r_state == ST_RUN) && !i_empty && (i_head.pos == '0) && !r_have;
    assign o_pop   = (r_state == ST_RUN) && !i_empty && can_out
                     && ((i_head.pos != '0) || r_have);
    assign ks_word = r_w[i_head.pos[5:2]];
    assign ks_byte = 8'(ks_word >> {i_head.pos[1:0], 3'b000});

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.out_last = r_ol;

    // Working state doubles as the keystream block once the final add is done.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_w <= init_w;
        end else if (r_state == ST_ROUND) begin
            r_w <= cc20_pkg::qr_step(r_w, r_rnd[0], r_step);
        end else if (r_state == ST_ADD) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= r_w[i] + init_w[i];
            end
        end
        if (o_pop) begin
            r_ob <= i_head.data ^ ks_byte;
            r_ol <= i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_step  <= '0;
            r_rnd   <= '0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (start) begin
                        r_state <= ST_ROUND;
                        r_step  <= '0;
                        r_rnd   <= '0;
                    end
                end
                ST_ROUND: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        if (r_rnd == RW'(ROUND_COUNT - 1)) begin
                            r_state <= ST_ADD;
                        end else begin
                            r_rnd <= r_rnd + 1'b1;
                        end
                    end
                end
                ST_ADD: begin
                    r_state <= ST_RUN;
                end
                default: r_state <= ST_RUN;
            endcase
            if (r_state == ST_ADD) begin
                r_have <= 1'b1;
            end else if (o_pop) begin
                r_have <= 1'b0;
            end
            if (o_pop) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

    a_round_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (!i_empty && i_head.pos == '0))
        else $error("head changed during block generation");

    a_add_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> (r_state == ST_RUN && r_have))
        else $error("block not marked ready after final add");

    a_block_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.pos == '0) |-> r_have)
        else $error("first byte of block left before keystream was ready");

endmodule

// ===== sv/chacha20_stream_cipher.sv =====
// ChaCha20 (96-bit nonce) byte stream cipher: top level with configuration registers.
// One byte goes in and one comes out per transfer, XORed with the keystream; the
// same operation encrypts and decrypts. Within a 64-byte block bytes stream at one
// per cycle while the output is not stalled; each byte is registered in the queue and
// then in the output register. The first byte of each block waits while the shared
// quarter-round unit generates the block: a load of the input state, one line of all
// four quarter rounds per cycle, then the add of the input state. A four-entry queue
// lets input keep arriving meanwhile. The block counter starts at 0 for each message
// and wraps modulo 2^32; a byte flagged last restarts position and counter. Key and
// nonce registers are 64-bit (NONCE1 keeps only 32 bits) at byte address 8*i and are
// sampled when a block is generated, so write them only while the block is idle. No
// clearing pass after reset.
module chacha20_stream_cipher #(
    parameter int ROUND_COUNT = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cc20_in_if.sink     i_in,
    cc20_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cc20_pkg::t_cfg  r_cfg;
    cc20_pkg::t_item push_item;
    cc20_pkg::t_item head;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                cc20_pkg::REG_KEY0:   r_cfg.key[0]   <= pwdata;
                cc20_pkg::REG_KEY1:   r_cfg.key[1]   <= pwdata;
                cc20_pkg::REG_KEY2:   r_cfg.key[2]   <= pwdata;
                cc20_pkg::REG_KEY3:   r_cfg.key[3]   <= pwdata;
                cc20_pkg::REG_NONCE0: r_cfg.nonce_lo <= pwdata;
                cc20_pkg::REG_NONCE1: r_cfg.nonce_hi <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cc20_pkg::REG_KEY0:   prdata = r_cfg.key[0];
            cc20_pkg::REG_KEY1:   prdata = r_cfg.key[1];
            cc20_pkg::REG_KEY2:   prdata = r_cfg.key[2];
            cc20_pkg::REG_KEY3:   prdata = r_cfg.key[3];
            cc20_pkg::REG_NONCE0: prdata = r_cfg.nonce_lo;
            cc20_pkg::REG_NONCE1: prdata = {32'h0, r_cfg.nonce_hi};
            default:              prdata = '0;
        endcase
    end

    cc20_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_item  (push_item)
    );

    cc20_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    cc20_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== tb/chacha20_stream_cipher_tb.sv =====
// Self-checking testbench for the ChaCha20 byte stream cipher with its own keystream predictor.
module chacha20_stream_cipher_tb;

    localparam int ROUNDS         = 20;
    localparam int PHASE_BYTES    = 280;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    // Register slots past the last defined one: writes there must be dropped.
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_cipher_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cc20_in_if  in_ch ();
    cc20_out_if out_ch ();

    chacha20_stream_cipher #(.ROUND_COUNT(ROUNDS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the configuration and the keystream state
    logic [63:0] key_pair [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] ks_words [16];
    logic [31:0] mix_words [16];
    logic [31:0] block_ctr;
    logic [5:0]  byte_pos;

    t_cipher_out expected_q [$];
    int          mismatch_count;
    int          idle_cycles;
    bit          src_idle_on;
    bit          sink_idle_on;
    int          sink_hold_cycles;

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_round(int a, int b, int c, int d);
        mix_words[a] += mix_words[b];
        mix_words[d] = rotl32(mix_words[d] ^ mix_words[a], 16);
        mix_words[c] += mix_words[d];
        mix_words[b] = rotl32(mix_words[b] ^ mix_words[c], 12);
        mix_words[a] += mix_words[b];
        mix_words[d] = rotl32(mix_words[d] ^ mix_words[a], 8);
        mix_words[c] += mix_words[d];
        mix_words[b] = rotl32(mix_words[b] ^ mix_words[c], 7);
    endfunction

    function automatic void generate_keystream();
        logic [31:0] init_w [16];
        for (int i = 0; i < 4; i++) begin
            init_w[i]         = cc20_pkg::SIGMA[i];
            init_w[4 + 2 * i] = key_pair[i][31:0];
            init_w[5 + 2 * i] = key_pair[i][63:32];
        end
        init_w[12] = block_ctr;
        init_w[13] = nonce_lo[31:0];
        init_w[14] = nonce_lo[63:32];
        init_w[15] = nonce_hi;
        mix_words = init_w;
        // Column rounds on even passes, diagonal rounds on odd ones
        for (int r = 0; r < ROUNDS; r++) begin
            if ((r % 2) == 0) begin
                quarter_round(0, 4, 8, 12);
                quarter_round(1, 5, 9, 13);
                quarter_round(2, 6, 10, 14);
                quarter_round(3, 7, 11, 15);
            end else begin
                quarter_round(0, 5, 10, 15);
                quarter_round(1, 6, 11, 12);
                quarter_round(2, 7, 8, 13);
                quarter_round(3, 4, 9, 14);
            end
        end
        for (int i = 0; i < 16; i++) ks_words[i] = mix_words[i] + init_w[i];
    endfunction

    function automatic t_cipher_out predict_cipher(logic [7:0] data, logic last);
        t_cipher_out r;
        logic [31:0] word;
        if (byte_pos == 6'd0) begin
            generate_keystream();
            block_ctr++;
        end
        word       = ks_words[byte_pos[5:2]];
        r.out_byte = data ^ word[8 * byte_pos[1:0] +: 8];
        r.out_last = last;
        // A last byte restarts position and counter for the next message
        if (last) begin
            byte_pos  = 6'd0;
            block_ctr = 32'd0;
        end else begin
            byte_pos = byte_pos + 6'd1;
        end
        return r;
    endfunction

    function automatic void store_config(logic [2:0] idx, logic [63:0] value);
        case (idx)
            cc20_pkg::REG_KEY0:   key_pair[0] = value;
            cc20_pkg::REG_KEY1:   key_pair[1] = value;
            cc20_pkg::REG_KEY2:   key_pair[2] = value;
            cc20_pkg::REG_KEY3:   key_pair[3] = value;
            cc20_pkg::REG_NONCE0: nonce_lo    = value;
            cc20_pkg::REG_NONCE1: nonce_hi    = value[31:0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        $display("[%0t] mismatch on %s: got %02h, expected %02h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        store_config(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all_regs(logic [63:0] value);
        reg_write(cc20_pkg::REG_KEY0, value);
        reg_write(cc20_pkg::REG_KEY1, value);
        reg_write(cc20_pkg::REG_KEY2, value);
        reg_write(cc20_pkg::REG_KEY3, value);
        reg_write(cc20_pkg::REG_NONCE0, value);
        reg_write(cc20_pkg::REG_NONCE1, value);
    endtask

    task automatic send_byte(logic [7:0] data, logic last);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= data;
        in_ch.last_in_message <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic release_source();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_zero_key_messages();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        // Single-byte message straight after a last byte
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        release_source();
        wait_drained();
    endtask

    task automatic test_key_change_mid_message();
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        release_source();
        wait_drained();
        // New key only reaches the keystream once the next block is built
        reg_write(cc20_pkg::REG_KEY0, {$urandom, $urandom});
        reg_write(cc20_pkg::REG_NONCE0, {$urandom, $urandom});
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h66, 1'b1);
        release_source();
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_all_regs({64{1'b1}});
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        release_source();
        wait_drained();
        // Writes past the register file must leave the keystream unchanged
        reg_write(REG_SPARE6, {$urandom, $urandom});
        reg_write(REG_SPARE7, {$urandom, $urandom});
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        release_source();
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle_on      = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 70; i++) send_byte(8'($urandom), i == 69);
        release_source();
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        for (int p = 0; p < 4; p++) begin
            release_source();
            wait_drained();
            // A message cut at the end of a phase carries on under the new config
            reg_write(cc20_pkg::REG_KEY0, {$urandom, $urandom});
            reg_write(cc20_pkg::REG_KEY1, {$urandom, $urandom});
            reg_write(cc20_pkg::REG_KEY2, {$urandom, $urandom});
            reg_write(cc20_pkg::REG_KEY3, {$urandom, $urandom});
            reg_write(cc20_pkg::REG_NONCE0, {$urandom, $urandom});
            reg_write(cc20_pkg::REG_NONCE1, {$urandom, $urandom});
            src_idle_on  = (p == 0 || p == 2);
            sink_idle_on = (p == 0 || p == 3);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len = $urandom_range(1, 16);
                    5, 6, 7:       len = $urandom_range(17, 140);
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       len = 63;
                            1:       len = 64;
                            2:       len = 65;
                            default: len = 128;
                        endcase
                    end
                endcase
                for (int i = 0; i < len && sent < PHASE_BYTES; i++) begin
                    send_byte(8'($urandom), i == len - 1);
                    sent++;
                end
            end
        end
        release_source();
        wait_drained();
    endtask

    // Receiver: random stalls, plus one long hold on request
    always begin
        @(negedge i_clk);
        if (sink_hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            repeat (sink_hold_cycles) @(negedge i_clk);
            sink_hold_cycles = 0;
        end else if (!sink_idle_on || $urandom_range(0, 3) != 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= 1'b0;
            repeat (pick_gap() - 1) @(negedge i_clk);
        end
    end

    // Predict on each input transfer, then check each output transfer
    always @(posedge i_clk) begin
        t_cipher_out want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(predict_cipher(in_ch.data_byte, in_ch.last_in_message));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected out_byte", out_ch.out_byte, 8'h00);
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                        report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
                    if (out_ch.out_last !== want.out_last)
                        report_mismatch("out_last", 8'(out_ch.out_last), 8'(want.out_last));
                end
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable && pwrite && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = 8'h00;
        in_ch.last_in_message = 1'b0;
        out_ch.ready          = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        i_rst_n               = 1'b0;
        src_idle_on           = 1'b0;
        sink_idle_on          = 1'b0;
        sink_hold_cycles      = 0;
        mismatch_count        = 0;
        idle_cycles           = 0;
        for (int i = 0; i < 4; i++) key_pair[i] = '0;
        nonce_lo  = '0;
        nonce_hi  = '0;
        block_ctr = '0;
        byte_pos  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_key_messages();
        test_key_change_mid_message();
        test_register_extremes();
        test_output_backpressure();
        test_random_messages();

        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cc20_pkg.sv
sv/cc20_if.sv
sv/cc20_fifo.sv
sv/cc20_front.sv
sv/cc20_back.sv
sv/chacha20_stream_cipher.sv
tb/chacha20_stream_cipher_tb.sv
